### rtl/core/assert_macros.svh
// assertion helpers used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition must hold whenever reset is low
`define ASSERT_ALWAYS(lbl, clk, rst, cond) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) \
    else $error("assertion failed");

// same-cycle implication
`define ASSERT_IMPL(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication
`define ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

### rtl/core/msmhp_pkg.sv
`default_nettype none
package msmhp_pkg;

  // header store depth in bytes
  localparam int HDR_DEPTH = 30;

  // largest cell count that still gives a cell mask
  localparam int MAX_CELLS = 64;

  // message number window that can hold MSM types
  localparam logic [11:0] MSM_TYPE_BASE = 12'd1070;
  localparam logic [11:0] MSM_TYPE_LAST = 12'd1139;

  // gnss code of glonass (day plus time-of-day epoch)
  localparam logic [2:0] GNSS_GLONASS = 3'd1;

  // milliseconds per day
  localparam logic [29:0] DAY_MS = 30'd86400000;

  typedef enum logic [1:0] {
    STATUS_OK       = 2'd0,
    STATUS_NOT_MSM  = 2'd1,
    STATUS_TOO_MANY = 2'd2
  } status_t;

  // one classified message waiting for field extraction
  typedef struct packed {
    status_t                     status;
    logic [2:0]                  gnss;
    logic [2:0]                  kind;
    logic [6:0]                  sat_cnt;
    logic [5:0]                  sig_cnt;
    logic [6:0]                  ncell;
    logic [HDR_DEPTH-1:0][7:0]   hdr;
  } entry_t;

endpackage
`default_nettype wire

### rtl/core/msmhp_queue.sv
`default_nettype none
module msmhp_queue (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            push,
  input  wire msmhp_pkg::entry_t push_entry,
  output logic                 full,
  input  wire logic            pop,
  output logic                 empty,
  output msmhp_pkg::entry_t    head
);
  import msmhp_pkg::*;

  entry_t     slots [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  assign full  = (count == 2'd2);
  assign empty = (count == 2'd0);
  assign head  = slots[rd_ptr];

  // entry storage
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_entry;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      if (push && !pop) begin
        count <= count + 2'd1;
      end else if (pop && !push) begin
        count <= count - 2'd1;
      end
    end
  end

endmodule
`default_nettype wire

### rtl/core/msmhp_front.sv
`default_nettype none
module msmhp_front (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic [7:0]      payload_byte,
  input  wire logic            start_of_message,
  input  wire logic            in_valid,
  output logic                 in_ready,
  input  wire logic            q_full,
  output logic                 q_push,
  output msmhp_pkg::entry_t    q_entry
);
  import msmhp_pkg::*;

  // byte positions of the message number end and of the masks
  localparam logic [4:0] TYPE_LAST_BYTE = 5'd1;
  localparam logic [4:0] SAT_FIRST_BYTE = 5'd9;
  localparam logic [4:0] SAT_LAST_BYTE  = 5'd16;
  localparam logic [4:0] SHARED_BYTE    = 5'd17;
  localparam logic [4:0] SIG_FIRST_BYTE = 5'd18;
  localparam logic [4:0] SIG_LAST_BYTE  = 5'd20;
  localparam logic [4:0] DECIDE_BYTE    = 5'd21;

  function automatic logic [3:0] pop8(input logic [7:0] v);
    logic [3:0] c;
    c = 4'd0;
    for (int i = 0; i < 8; i++) begin
      c = c + {3'd0, v[i]};
    end
    return c;
  endfunction

  logic [7:0]  hdr [HDR_DEPTH];
  logic [4:0]  byte_count;
  logic        reported;
  logic [6:0]  sat_cnt;
  logic [5:0]  sig_cnt;
  logic [2:0]  gnss_r;
  logic [2:0]  kind_r;
  logic [4:0]  need_r;
  logic [6:0]  ncell_r;

  logic        fire;
  logic [4:0]  idx;
  logic [4:0]  idx_inc;
  logic        rep;
  logic        store;
  logic [11:0] type_now;
  logic [11:0] type_off;
  logic [14:0] tens_prod;
  logic [3:0]  tens;
  logic [6:0]  units_full;
  logic [3:0]  units;
  logic        in_window;
  logic        msm_ok;
  logic [3:0]  sat_add;
  logic [3:0]  sig_add;
  logic [6:0]  sat_next;
  logic [5:0]  sig_next;
  logic [12:0] ncell;
  logic        too_many;
  logic [12:0] need_sum;
  logic [4:0]  need_now;
  logic        emit;
  status_t     emit_status;
  logic [HDR_DEPTH-1:0][7:0] snap;

  assign in_ready = !q_full;
  assign fire     = in_valid && !q_full;

  // position of the incoming byte
  assign idx     = start_of_message ? 5'd0 : byte_count;
  assign idx_inc = idx + 5'd1;
  assign rep     = start_of_message ? 1'b0 : reported;
  assign store   = fire && !rep && (idx < 5'(HDR_DEPTH));

  // message number split into tens and units by reciprocal multiply
  assign type_now   = {hdr[0], payload_byte[7:4]};
  assign in_window  = (type_now >= MSM_TYPE_BASE) && (type_now <= MSM_TYPE_LAST);
  assign type_off   = type_now - MSM_TYPE_BASE;
  assign tens_prod  = 15'(type_off[6:0]) * 15'd205;
  assign tens       = tens_prod[14:11];
  assign units_full = type_off[6:0] - 7'(7'(tens) * 7'd10);
  assign units      = units_full[3:0];
  assign msm_ok     = in_window && (units >= 4'd1) && (units <= 4'd7);

  // mask popcount contributions of this byte
  always_comb begin
    sat_add = 4'd0;
    sig_add = 4'd0;
    case (idx) inside
      SAT_FIRST_BYTE:                     sat_add = pop8({1'b0, payload_byte[6:0]});
      [5'd10:SAT_LAST_BYTE]:              sat_add = pop8(payload_byte);
      SHARED_BYTE: begin
        sat_add = {3'd0, payload_byte[7]};
        sig_add = pop8({1'b0, payload_byte[6:0]});
      end
      [SIG_FIRST_BYTE:SIG_LAST_BYTE]:     sig_add = pop8(payload_byte);
      DECIDE_BYTE:                        sig_add = {3'd0, payload_byte[7]};
      default: begin
        sat_add = 4'd0;
        sig_add = 4'd0;
      end
    endcase
  end

  assign sat_next = (idx == 5'd0) ? 7'd0 : sat_cnt + 7'(sat_add);
  assign sig_next = (idx == 5'd0) ? 6'd0 : sig_cnt + 6'(sig_add);

  // cell count and the byte count that completes the cell mask
  assign ncell    = 13'(sat_next) * 13'(sig_next);
  assign too_many = ncell > 13'(MAX_CELLS);
  assign need_sum = ncell + 13'd176;
  assign need_now = need_sum[7:3];

  // decide whether this byte finishes the message
  always_comb begin
    emit        = 1'b0;
    emit_status = STATUS_OK;
    if (store) begin
      if (idx == TYPE_LAST_BYTE) begin
        if (!msm_ok) begin
          emit        = 1'b1;
          emit_status = STATUS_NOT_MSM;
        end
      end else if (idx == DECIDE_BYTE) begin
        if (too_many) begin
          emit        = 1'b1;
          emit_status = STATUS_TOO_MANY;
        end else if (need_now == idx_inc) begin
          emit = 1'b1;
        end
      end else if (idx > DECIDE_BYTE) begin
        emit = (need_r == idx_inc);
      end
    end
  end

  // header image including the incoming byte
  always_comb begin
    for (int i = 0; i < HDR_DEPTH; i++) begin
      snap[i] = (store && (idx == 5'(i))) ? payload_byte : hdr[i];
    end
  end

  assign q_push            = emit;
  assign q_entry.status    = emit_status;
  assign q_entry.gnss      = gnss_r;
  assign q_entry.kind      = kind_r;
  assign q_entry.sat_cnt   = sat_next;
  assign q_entry.sig_cnt   = sig_next;
  assign q_entry.ncell     = (idx == DECIDE_BYTE) ? ncell[6:0] : ncell_r;
  assign q_entry.hdr       = snap;

  // header bytes and per-message fields
  always_ff @(posedge clk) begin
    if (store) begin
      hdr[idx] <= payload_byte;
      sat_cnt  <= sat_next;
      sig_cnt  <= sig_next;
      if (idx == TYPE_LAST_BYTE) begin
        gnss_r <= tens[2:0];
        kind_r <= units[2:0];
      end
      if (idx == DECIDE_BYTE) begin
        need_r  <= need_now;
        ncell_r <= ncell[6:0];
      end
    end
  end

  // byte count and reported flag
  always_ff @(posedge clk) begin
    if (rst) begin
      byte_count <= 5'd0;
      reported   <= 1'b1;
    end else if (fire) begin
      if (store) begin
        byte_count <= idx_inc;
      end else begin
        byte_count <= idx;
      end
      reported <= rep || emit;
    end
  end

endmodule
`default_nettype wire

### rtl/core/msmhp_back.sv
`default_nettype none
module msmhp_back (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            q_empty,
  input  wire msmhp_pkg::entry_t q_head,
  output logic                 q_pop,
  output logic                 out_valid,
  input  wire logic            out_ready,
  output logic [1:0]           status,
  output logic [11:0]          message_type,
  output logic [11:0]          station_id,
  output logic [29:0]          epoch_ms,
  output logic [2:0]           gnss_code,
  output logic [2:0]           msm_kind,
  output logic [11:0]          flag_bits,
  output logic [63:0]          satellite_mask,
  output logic [31:0]          signal_mask,
  output logic [6:0]           satellite_count,
  output logic [5:0]           signal_count,
  output logic [63:0]          cell_mask
);
  import msmhp_pkg::*;

  logic [HDR_DEPTH-1:0][7:0] h;
  logic        is_msm;
  logic        is_ok;
  logic [2:0]  day;
  logic [26:0] tod;
  logic [29:0] epoch_raw;
  logic [29:0] epoch_glo;
  logic [29:0] epoch_sel;
  logic [63:0] cell_win;
  logic [5:0]  cell_sh;
  logic [63:0] cell_sel;
  logic        load;

  assign h      = q_head.hdr;
  assign is_msm = (q_head.status != STATUS_NOT_MSM);
  assign is_ok  = (q_head.status == STATUS_OK);

  // epoch, with glonass day folded into milliseconds
  assign day       = h[3][7:5];
  assign tod       = {h[3][4:0], h[4], h[5], h[6][7:2]};
  assign epoch_raw = {h[3], h[4], h[5], h[6][7:2]};
  assign epoch_glo = 30'(30'(day) * DAY_MS) + 30'(tod);
  assign epoch_sel = (q_head.gnss == GNSS_GLONASS) ? epoch_glo : epoch_raw;

  // cell mask window from bit 169, right aligned by the cell count
  assign cell_win = {h[21][6:0], h[22], h[23], h[24], h[25], h[26], h[27], h[28], h[29][7]};
  assign cell_sh  = 6'(7'd64 - q_head.ncell);
  assign cell_sel = (is_ok && (q_head.ncell != 7'd0)) ? (cell_win >> cell_sh) : 64'd0;

  assign load  = !q_empty && (!out_valid || out_ready);
  assign q_pop = load;

  // output register valid
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // output register payload
  always_ff @(posedge clk) begin
    if (load) begin
      status          <= q_head.status;
      message_type    <= {h[0], h[1][7:4]};
      station_id      <= is_msm ? {h[1][3:0], h[2]} : 12'd0;
      epoch_ms        <= is_msm ? epoch_sel : 30'd0;
      gnss_code       <= is_msm ? q_head.gnss : 3'd0;
      msm_kind        <= is_msm ? q_head.kind : 3'd0;
      flag_bits       <= is_msm ? {h[6][1:0], h[7][7:6], h[8][6:0], h[9][7]} : 12'd0;
      satellite_mask  <= is_msm ?
                         {h[9][6:0], h[10], h[11], h[12], h[13], h[14], h[15], h[16], h[17][7]}
                         : 64'd0;
      signal_mask     <= is_msm ? {h[17][6:0], h[18], h[19], h[20], h[21][7]} : 32'd0;
      satellite_count <= is_msm ? q_head.sat_cnt : 7'd0;
      signal_count    <= is_msm ? q_head.sig_cnt : 6'd0;
      cell_mask       <= cell_sel;
    end
  end

endmodule
`default_nettype wire

### rtl/core/rtcm3_msm_header_parse.sv
`default_nettype none
// RTCM3 MSM header parser. Feed the payload bytes of one message (after the
// 3-byte frame header), MSB first, one per transaction, with start_of_message
// on the first. One result per message comes out: status 1 right after the
// second byte for a non-MSM number, status 2 after the 22nd byte when the
// satellite by signal cell count exceeds 64, otherwise status 0 once the
// byte holding the last cell mask bit is in. A message cut short by the next
// start gives no result. The input takes one byte every cycle while in_ready
// is high; a result passes through a queue slot and the output register
// before it shows. A two-entry queue sits between the byte front end and the
// output register, so input stalls only when that register holds a result
// under a low out_ready and two more finished results fill the queue behind it.
module rtcm3_msm_header_parse (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [7:0]  payload_byte,
  input  wire logic        start_of_message,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [1:0]       status,
  output logic [11:0]      message_type,
  output logic [11:0]      station_id,
  output logic [29:0]      epoch_ms,
  output logic [2:0]       gnss_code,
  output logic [2:0]       msm_kind,
  output logic [11:0]      flag_bits,
  output logic [63:0]      satellite_mask,
  output logic [31:0]      signal_mask,
  output logic [6:0]       satellite_count,
  output logic [5:0]       signal_count,
  output logic [63:0]      cell_mask
);
  import msmhp_pkg::*;

  logic   q_push;
  logic   q_full;
  logic   q_pop;
  logic   q_empty;
  entry_t q_entry;
  entry_t q_head;

  // byte intake and message classification
  msmhp_front u_front (
    .clk              (clk),
    .rst              (rst),
    .payload_byte     (payload_byte),
    .start_of_message (start_of_message),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .q_full           (q_full),
    .q_push           (q_push),
    .q_entry          (q_entry)
  );

  // queue of classified messages
  msmhp_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (q_push),
    .push_entry (q_entry),
    .full       (q_full),
    .pop        (q_pop),
    .empty      (q_empty),
    .head       (q_head)
  );

  // field extraction and output register
  msmhp_back u_back (
    .clk             (clk),
    .rst             (rst),
    .q_empty         (q_empty),
    .q_head          (q_head),
    .q_pop           (q_pop),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .status          (status),
    .message_type    (message_type),
    .station_id      (station_id),
    .epoch_ms        (epoch_ms),
    .gnss_code       (gnss_code),
    .msm_kind        (msm_kind),
    .flag_bits       (flag_bits),
    .satellite_mask  (satellite_mask),
    .signal_mask     (signal_mask),
    .satellite_count (satellite_count),
    .signal_count    (signal_count),
    .cell_mask       (cell_mask)
  );

endmodule
`default_nettype wire

### rtl/core/msmhp_checker.sv
`default_nettype none
`include "assert_macros.svh"
module msmhp_checker (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        out_valid,
  input  wire logic        out_ready,
  input  wire logic [1:0]  status,
  input  wire logic [11:0] message_type,
  input  wire logic [11:0] station_id,
  input  wire logic [29:0] epoch_ms,
  input  wire logic [2:0]  gnss_code,
  input  wire logic [2:0]  msm_kind,
  input  wire logic [11:0] flag_bits,
  input  wire logic [63:0] satellite_mask,
  input  wire logic [31:0] signal_mask,
  input  wire logic [6:0]  satellite_count,
  input  wire logic [5:0]  signal_count,
  input  wire logic [63:0] cell_mask
);
  import msmhp_pkg::*;

  logic         not_msm;
  logic         msm_res;
  logic [12:0]  cells;
  logic         rest_zero;
  logic         decode_ok;
  logic         counts_ok;
  logic         cells_ok;
  logic [107:0] out_word;

  assign not_msm = out_valid && (status == STATUS_NOT_MSM);
  assign msm_res = out_valid && (status != STATUS_NOT_MSM);
  assign cells   = 13'(satellite_count) * 13'(signal_count);

  // every field but the message number is zero
  assign rest_zero = (station_id == 12'd0) && (epoch_ms == 30'd0) && (gnss_code == 3'd0)
                     && (msm_kind == 3'd0) && (flag_bits == 12'd0)
                     && (satellite_mask == 64'd0) && (signal_mask == 32'd0)
                     && (satellite_count == 7'd0) && (signal_count == 6'd0)
                     && (cell_mask == 64'd0);

  // number, system and kind of an MSM result
  assign decode_ok = (status == STATUS_OK || status == STATUS_TOO_MANY)
                     && (message_type >= 12'd1071) && (message_type <= 12'd1137)
                     && (msm_kind >= 3'd1) && (msm_kind <= 3'd7) && (gnss_code <= 3'd6);

  // popcounts of the masks
  assign counts_ok = (satellite_count == 7'($countones(satellite_mask)))
                     && (signal_count == 6'($countones(signal_mask)));

  // status against the cell count
  assign cells_ok = ((status == STATUS_TOO_MANY) && (cells > 13'(MAX_CELLS))
                     && (cell_mask == 64'd0))
                    || ((status == STATUS_OK) && (cells <= 13'(MAX_CELLS)));

  assign out_word = {status, message_type, epoch_ms, cell_mask};

  // non-MSM results carry only the message number
  `ASSERT_IMPL(a_not_msm_clear, clk, rst, not_msm, rest_zero)

  // MSM results have a consistent number, system and kind
  `ASSERT_IMPL(a_msm_decode, clk, rst, msm_res, decode_ok)

  // counts agree with the masks they describe
  `ASSERT_IMPL(a_counts_match, clk, rst, msm_res, counts_ok)

  // status follows the cell count, and an overflow carries no cell mask
  `ASSERT_IMPL(a_cell_limit, clk, rst, msm_res, cells_ok)

  // a stalled result holds its status, number, epoch and cell mask
  `ASSERT_NEXT(a_out_hold, clk, rst, out_valid && !out_ready, out_valid && $stable(out_word))

endmodule

bind rtcm3_msm_header_parse msmhp_checker u_msmhp_checker (.*);
`default_nettype wire
